[rtl/hgss_pkg.sv]
// hgss_pkg: shared types and constants of the hybrid gait step search
// angle constants in Q8.16, register indexes, config and result structs
// no dependencies
package hgss_pkg;

   localparam int          ANG_W       = 24;
   localparam int          LEN_W       = 16;
   localparam int          CNT_OUT_W   = 3;
   localparam int          CSR_IDX_W   = 2;

   // working width of the angle wrap, holds the biased leg-plus-pitch value
   localparam int          WRAP_W      = 26;
   localparam int          WRAP_STEPS  = 7;
   localparam int          TWO_PI_VAL  = 411775;

   localparam logic [WRAP_W-1:0] ANG_TWO_PI  = 26'd411775;
   localparam logic [WRAP_W-1:0] ANG_HALF_PI = 26'd102944;
   // multiple of 2pi that lifts every leg-plus-pitch value above zero
   localparam logic [WRAP_W-1:0] WRAP_BIAS   = 26'd17294550;
   localparam logic [WRAP_W-1:0] WRAP_OFFSET = WRAP_BIAS - ANG_HALF_PI;

   localparam logic [CSR_IDX_W-1:0] CSR_WHEEL_RADIUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE_MIN   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE_MAX   = 2'd2;

   localparam logic [LEN_W-1:0] WHEEL_RADIUS_RST = 16'd7209;
   localparam logic [LEN_W-1:0] STRIDE_MIN_RST   = 16'd6554;
   localparam logic [LEN_W-1:0] STRIDE_MAX_RST   = 16'd13107;

   typedef struct packed {
      logic [LEN_W-1:0] wheel_radius;
      logic [LEN_W-1:0] stride_min;
      logic [LEN_W-1:0] stride_max;
   } cfg_type;

   typedef struct packed {
      logic                 valid;
      logic [CNT_OUT_W-1:0] step_count;
      logic [LEN_W-1:0]     stride_len;
   } rsp_type;

endpackage

[rtl/hgss_alu.sv]
// hgss_alu: shared subtract and compare unit
// used by the angle wrap and by the step length divider
// depends on hgss_pkg
module hgss_alu (
   input  logic [hgss_pkg::WRAP_W-1:0] a,
   input  logic [hgss_pkg::WRAP_W-1:0] b,
   output logic [hgss_pkg::WRAP_W-1:0] diff,
   output logic                        ge
);

   logic [hgss_pkg::WRAP_W:0] full;

   assign full = {1'b0, a} - {1'b0, b};
   assign diff = full[hgss_pkg::WRAP_W-1:0];
   assign ge   = ~full[hgss_pkg::WRAP_W];

endmodule

[rtl/hgss_ctrl.sv]
// hgss_ctrl: sequencer of the step search
// wraps both leg angles, then multiplies and divides once per tried count
// depends on hgss_pkg and hgss_alu
module hgss_ctrl #(
   parameter int MAX_STEPS = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [hgss_pkg::ANG_W-1:0]   right_angle,
   input  logic signed [hgss_pkg::ANG_W-1:0]   left_angle,
   input  logic signed [hgss_pkg::ANG_W-1:0]   pitch_angle,
   input  hgss_pkg::cfg_type                   cfg,
   output logic                                busy,
   output hgss_pkg::rsp_type                   rsp
);

   localparam int CW    = $clog2(MAX_STEPS + 1);
   localparam int DW    = $clog2((MAX_STEPS / 2 + 2) * hgss_pkg::TWO_PI_VAL);
   localparam int PW    = hgss_pkg::LEN_W + DW;
   localparam int BW    = $clog2(DW);
   localparam int WW    = hgss_pkg::WRAP_W;
   localparam int KW    = $clog2(hgss_pkg::WRAP_STEPS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRAP,
      ST_MUL,
      ST_DIV,
      ST_CHECK
   } state_type;

   state_type           state_ff, state_in;
   logic [WW-1:0]       work_ff, work_in;
   logic [WW-1:0]       pend_ff, pend_in;
   logic [KW-1:0]       k_ff, k_in;
   logic                leg_ff, leg_in;
   logic [DW-1:0]       d_right_ff, d_right_in;
   logic [DW-1:0]       d_left_ff, d_left_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [DW-1:0]       num_ff, num_in;
   logic [CW-1:0]       prem_ff, prem_in;
   logic [BW-1:0]       bit_ff, bit_in;
   hgss_pkg::rsp_type   rsp_ff, rsp_in;

   logic [WW-1:0]       alu_a, alu_b, alu_diff;
   logic                alu_ge;
   logic signed [WW:0]  sum_right, sum_left;
   logic [WW-1:0]       wrap_res;
   logic [CW:0]         div_t;
   logic [DW-1:0]       delta;
   logic [PW-1:0]       prod;
   logic [DW-1:0]       min_len, max_len;
   logic [CW+2:0]       count_wide;

   hgss_alu u_alu (
      .a    (alu_a),
      .b    (alu_b),
      .diff (alu_diff),
      .ge   (alu_ge)
   );

   assign sum_right = {{3{right_angle[hgss_pkg::ANG_W-1]}}, right_angle}
                    + {{3{pitch_angle[hgss_pkg::ANG_W-1]}}, pitch_angle}
                    + {1'b0, hgss_pkg::WRAP_OFFSET};
   assign sum_left  = {{3{left_angle[hgss_pkg::ANG_W-1]}}, left_angle}
                    + {{3{pitch_angle[hgss_pkg::ANG_W-1]}}, pitch_angle}
                    + {1'b0, hgss_pkg::WRAP_OFFSET};

   assign div_t      = {prem_ff, num_ff[DW-1]};
   assign wrap_res   = alu_ge ? alu_diff : work_ff;
   assign delta      = count_ff[0] ? d_right_ff : d_left_ff;
   assign prod       = PW'(cfg.wheel_radius) * PW'(delta);
   assign min_len    = DW'(cfg.stride_min);
   assign max_len    = DW'(cfg.stride_max);
   assign count_wide = {3'b000, count_ff};

   always_comb begin
      alu_a = work_ff;
      alu_b = hgss_pkg::ANG_TWO_PI << k_ff;
      if (state_ff == ST_DIV) begin
         alu_a = WW'(div_t);
         alu_b = WW'(count_ff);
      end
   end

   always_comb begin
      state_in   = state_ff;
      work_in    = work_ff;
      pend_in    = pend_ff;
      k_in       = k_ff;
      leg_in     = leg_ff;
      d_right_in = d_right_ff;
      d_left_in  = d_left_ff;
      count_in   = count_ff;
      num_in     = num_ff;
      prem_in    = prem_ff;
      bit_in     = bit_ff;
      rsp_in     = rsp_ff;
      rsp_in.valid = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               work_in  = sum_right[WW-1:0];
               pend_in  = sum_left[WW-1:0];
               k_in     = KW'(hgss_pkg::WRAP_STEPS - 1);
               leg_in   = 1'b0;
               state_in = ST_WRAP;
            end
         end
         ST_WRAP: begin
            work_in = wrap_res;
            k_in    = k_ff - 1'b1;
            if (k_ff == '0) begin
               k_in = KW'(hgss_pkg::WRAP_STEPS - 1);
               if (!leg_ff) begin
                  d_right_in = wrap_res[DW-1:0];
                  work_in    = pend_ff;
                  leg_in     = 1'b1;
               end else begin
                  d_left_in = wrap_res[DW-1:0];
                  count_in  = CW'(1);
                  state_in  = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            num_in   = prod[PW-1:hgss_pkg::LEN_W];
            prem_in  = '0;
            bit_in   = BW'(DW - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            prem_in = alu_ge ? alu_diff[CW-1:0] : div_t[CW-1:0];
            num_in  = {num_ff[DW-2:0], alu_ge};
            bit_in  = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (num_ff < min_len) begin
               if (count_ff[0]) begin
                  d_right_in = d_right_ff + DW'(hgss_pkg::TWO_PI_VAL);
               end else begin
                  d_left_in = d_left_ff + DW'(hgss_pkg::TWO_PI_VAL);
               end
            end
            priority if (num_ff > min_len && num_ff < max_len) begin
               rsp_in.valid      = 1'b1;
               rsp_in.step_count = count_wide[2:0];
               rsp_in.stride_len = num_ff[hgss_pkg::LEN_W-1:0];
               state_in          = ST_IDLE;
            end else if (count_ff == CW'(MAX_STEPS)) begin
               rsp_in.valid      = 1'b1;
               rsp_in.step_count = '0;
               rsp_in.stride_len = '0;
               state_in          = ST_IDLE;
            end else begin
               count_in = count_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_ff.valid <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_ff.valid <= rsp_in.valid;
      end
      rsp_ff.step_count <= rsp_in.step_count;
      rsp_ff.stride_len <= rsp_in.stride_len;
      work_ff    <= work_in;
      pend_ff    <= pend_in;
      k_ff       <= k_in;
      leg_ff     <= leg_in;
      d_right_ff <= d_right_in;
      d_left_ff  <= d_left_in;
      count_ff   <= count_in;
      num_ff     <= num_in;
      prem_ff    <= prem_in;
      bit_ff     <= bit_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp  = rsp_ff;

endmodule

[rtl/hybrid_gait_step_search.sv]
// a search wraps both legs, then tries n counts (1 to MAX_STEPS), each with a multiply, a
// divide of D bits, D being the divider width (21 for MAX_STEPS = 6), and a check; a new
// beat is taken in the cycle the result shows
// the shared subtract unit runs seven steps per leg for the wrap, one bit per divide step
// reset (synchronous, active high) clears the sequencer and loads the register defaults
// results are a one-cycle strobe, the receiver cannot stall
module hybrid_gait_step_search #(
   parameter int MAX_STEPS = 6
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   output logic                                        busy,
   input  logic signed [hgss_pkg::ANG_W-1:0]           req_right_rear_angle,
   input  logic signed [hgss_pkg::ANG_W-1:0]           req_left_rear_angle,
   input  logic signed [hgss_pkg::ANG_W-1:0]           req_pitch_angle,
   output logic                                        rsp_valid,
   output logic [hgss_pkg::CNT_OUT_W-1:0]              rsp_step_count,
   output logic [hgss_pkg::LEN_W-1:0]                  rsp_stride_len,
   input  logic                                        csr_write_enable,
   input  logic [hgss_pkg::CSR_IDX_W-1:0]              csr_index,
   input  logic [hgss_pkg::LEN_W-1:0]                  csr_wdata
);

   hgss_pkg::cfg_type cfg_ff, cfg_in;
   hgss_pkg::rsp_type rsp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            hgss_pkg::CSR_WHEEL_RADIUS: cfg_in.wheel_radius = csr_wdata;
            hgss_pkg::CSR_STRIDE_MIN:   cfg_in.stride_min   = csr_wdata;
            hgss_pkg::CSR_STRIDE_MAX:   cfg_in.stride_max   = csr_wdata;
            default:                    cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wheel_radius <= hgss_pkg::WHEEL_RADIUS_RST;
         cfg_ff.stride_min   <= hgss_pkg::STRIDE_MIN_RST;
         cfg_ff.stride_max   <= hgss_pkg::STRIDE_MAX_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hgss_ctrl #(
      .MAX_STEPS (MAX_STEPS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .right_angle (req_right_rear_angle),
      .left_angle  (req_left_rear_angle),
      .pitch_angle (req_pitch_angle),
      .cfg         (cfg_ff),
      .busy        (busy),
      .rsp         (rsp)
   );

   assign rsp_valid      = rsp.valid;
   assign rsp_step_count = rsp.step_count;
   assign rsp_stride_len = rsp.stride_len;

endmodule

[rtl/hgss_checker.sv]
// hgss_checker: port-level checks of the step search, bound to the top level
// depends on hybrid_gait_step_search and hgss_pkg
module hgss_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic                               rsp_valid,
   input  logic [hgss_pkg::CNT_OUT_W-1:0]     rsp_step_count,
   input  logic [hgss_pkg::LEN_W-1:0]         rsp_stride_len
);

   // an accepted beat keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   // a result only ends a busy period
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("result beat outside the end of a search");

   // a result strobe is never followed directly by another
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // zero count goes with zero length and the other way round
   a_rsp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_step_count == '0) == (rsp_stride_len == '0)))
      else $error("step count and stride disagree on no result");

endmodule

bind hybrid_gait_step_search hgss_checker u_hgss_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_step_count (rsp_step_count),
   .rsp_stride_len (rsp_stride_len)
);
